@@ hdl/rrqs_pkg.sv @@
// ----------------------------------------------------------------------------
// rrqs_pkg
// types and constants shared by the round-robin quantum scheduler
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rrqs_pkg;

    localparam int THREAD_W    = 4;
    localparam int MAX_THREADS = 2 ** THREAD_W;
    localparam int QUANTUM_W   = 8;
    localparam int TOTAL_W     = 32;

    localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 8'd12;

    typedef enum logic [1:0] {
        CMD_TICK    = 2'd0,
        CMD_ENQUEUE = 2'd1,
        CMD_DEQUEUE = 2'd2,
        CMD_YIELD   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_DUP    = 2'd2,
        ST_ABSENT = 2'd3
    } status_t;

    typedef struct packed {
        cmd_t                cmd;
        logic [THREAD_W-1:0] thread_id;
    } req_t;

    typedef struct packed {
        logic [THREAD_W-1:0] running_thread;
        logic                switched;
        logic                running;
        status_t             status;
        logic [TOTAL_W-1:0]  total_ticks;
    } rsp_t;

endpackage

@@ hdl/round_robin_quantum_scheduler_top.sv @@
// ----------------------------------------------------------------------------
// round_robin_quantum_scheduler_top
// round-robin time-slice scheduler over a linked run queue of 16 threads
// path: input register, then the combinational core, then the result register
// throughput: one request per cycle unless rsp_stall backs up, one core pass per command
// reset: asynchronous active-low, empties the queue, clears counters, quantum back to 12
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module round_robin_quantum_scheduler_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [rrqs_pkg::QUANTUM_W-1:0] cfg_wdata,
    input  logic                           req_valid,
    output logic                           req_stall,
    input  rrqs_pkg::req_t                 req,
    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output rrqs_pkg::rsp_t                 rsp
);
    import rrqs_pkg::*;

    logic item_valid;
    req_t item;
    logic room;
    logic fire;
    rsp_t rsp_next;

    assign fire = item_valid && room;

    rrqs_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .take       (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    rrqs_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .fire      (fire),
        .item      (item),
        .rsp_next  (rsp_next)
    );

    rrqs_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire),
        .rsp_next  (rsp_next),
        .room      (room),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

@@ hdl/rrqs_in_reg.sv @@
// ----------------------------------------------------------------------------
// rrqs_in_reg
// input register: holds one request until the scheduler core takes it
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rrqs_in_reg (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  rrqs_pkg::req_t req,
    input  logic          take,
    output logic          item_valid,
    output rrqs_pkg::req_t item
);
    import rrqs_pkg::*;

    logic valid_reg;
    logic valid_next;
    req_t req_reg;
    logic load;

    // a held request may be replaced in the same cycle it is taken
    assign req_stall  = valid_reg && !take;
    assign load       = req_valid && !req_stall;
    assign valid_next = load ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            req_reg <= req;
        end
    end

    assign item_valid = valid_reg;
    assign item       = req_reg;

endmodule

@@ hdl/rrqs_core.sv @@
// ----------------------------------------------------------------------------
// rrqs_core
// run queue links, slice counters and tick logic; commits one request per fire
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rrqs_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [rrqs_pkg::QUANTUM_W-1:0]   cfg_wdata,
    input  logic                             fire,
    input  rrqs_pkg::req_t                   item,
    output rrqs_pkg::rsp_t                   rsp_next
);
    import rrqs_pkg::*;

    logic [QUANTUM_W-1:0] quantum_reg;

    logic [THREAD_W-1:0]  next_link_reg [MAX_THREADS];
    logic [THREAD_W-1:0]  prev_link_reg [MAX_THREADS];
    logic [QUANTUM_W-1:0] slice_count_reg [MAX_THREADS];

    logic [MAX_THREADS-1:0] queued_mask_reg, queued_mask_next;
    logic [THREAD_W-1:0]    head_reg, head_next;
    logic [THREAD_W-1:0]    tail_reg, tail_next;
    logic [THREAD_W-1:0]    current_reg, current_next;
    logic                   started_reg, started_next;
    logic [TOTAL_W-1:0]     total_reg, total_next;

    // one read and one write port per link array
    logic [THREAD_W-1:0]  nl_raddr, nl_rdata, pl_rdata;
    logic                 nl_we, pl_we;
    logic [THREAD_W-1:0]  nl_waddr, nl_wdata, pl_waddr, pl_wdata;
    logic                 sc_we;
    logic [QUANTUM_W-1:0] sc_wdata;

    logic [QUANTUM_W-1:0] slice_cur;
    logic [QUANTUM_W:0]   slice_inc;
    logic                 queue_empty;
    logic                 id_queued;
    logic                 cur_queued;
    logic [THREAD_W-1:0]  succ;
    logic                 switched;
    status_t              status;

    assign queue_empty = (queued_mask_reg == '0);
    assign id_queued   = queued_mask_reg[item.thread_id];
    assign cur_queued  = queued_mask_reg[current_reg];
    assign slice_cur   = slice_count_reg[current_reg];
    assign slice_inc   = {1'b0, slice_cur} + {{QUANTUM_W{1'b0}}, 1'b1};

    assign nl_raddr = (item.cmd == CMD_TICK) ? current_reg : item.thread_id;
    assign nl_rdata = next_link_reg[nl_raddr];
    assign pl_rdata = prev_link_reg[item.thread_id];

    // successor of the current thread, wrapping to the head
    assign succ = (!cur_queued || current_reg == tail_reg) ? head_reg : nl_rdata;

    always_comb
    begin
        queued_mask_next = queued_mask_reg;
        head_next        = head_reg;
        tail_next        = tail_reg;
        current_next     = current_reg;
        started_next     = started_reg;
        total_next       = total_reg;
        nl_we            = 1'b0;
        nl_waddr         = tail_reg;
        nl_wdata         = item.thread_id;
        pl_we            = 1'b0;
        pl_waddr         = item.thread_id;
        pl_wdata         = tail_reg;
        sc_we            = 1'b0;
        sc_wdata         = slice_inc[QUANTUM_W-1:0];
        switched         = 1'b0;
        status           = ST_OK;

        unique case (item.cmd)
            CMD_TICK:
            begin
                if (!started_reg)
                begin
                    if (queue_empty)
                    begin
                        status = ST_EMPTY;
                    end
                    else
                    begin
                        current_next = head_reg;
                        started_next = 1'b1;
                        switched     = 1'b1;
                    end
                end
                else
                begin
                    total_next = total_reg + {{(TOTAL_W-1){1'b0}}, 1'b1};
                    sc_we      = 1'b1;
                    if (slice_inc > {1'b0, quantum_reg})
                    begin
                        sc_wdata = '0;
                        if (!queue_empty && succ != current_reg)
                        begin
                            current_next = succ;
                            switched     = 1'b1;
                        end
                    end
                end
            end
            CMD_ENQUEUE:
            begin
                if (id_queued)
                begin
                    status = ST_DUP;
                end
                else
                begin
                    if (queue_empty)
                    begin
                        head_next = item.thread_id;
                    end
                    else
                    begin
                        nl_we = 1'b1;
                        pl_we = 1'b1;
                    end
                    tail_next                         = item.thread_id;
                    queued_mask_next[item.thread_id]  = 1'b1;
                end
            end
            CMD_DEQUEUE:
            begin
                if (!id_queued)
                begin
                    status = ST_ABSENT;
                end
                else
                begin
                    if (item.thread_id == head_reg && item.thread_id == tail_reg)
                    begin
                        head_next = '0;
                        tail_next = '0;
                    end
                    else if (item.thread_id == head_reg)
                    begin
                        head_next = nl_rdata;
                    end
                    else if (item.thread_id == tail_reg)
                    begin
                        tail_next = pl_rdata;
                    end
                    else
                    begin
                        // unlink from the middle of the queue
                        nl_we    = 1'b1;
                        nl_waddr = pl_rdata;
                        nl_wdata = nl_rdata;
                        pl_we    = 1'b1;
                        pl_waddr = nl_rdata;
                        pl_wdata = pl_rdata;
                    end
                    queued_mask_next[item.thread_id] = 1'b0;
                end
            end
            CMD_YIELD:
            begin
                sc_we    = 1'b1;
                sc_wdata = quantum_reg;
            end
        endcase
    end

    assign rsp_next.running_thread = current_next;
    assign rsp_next.switched       = switched;
    assign rsp_next.running        = started_next;
    assign rsp_next.status         = status;
    assign rsp_next.total_ticks    = total_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quantum_reg <= QUANTUM_RESET;
        end
        else if (cfg_we)
        begin
            quantum_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            queued_mask_reg <= '0;
            head_reg        <= '0;
            tail_reg        <= '0;
            current_reg     <= '0;
            started_reg     <= 1'b0;
            total_reg       <= '0;
        end
        else if (fire)
        begin
            queued_mask_reg <= queued_mask_next;
            head_reg        <= head_next;
            tail_reg        <= tail_next;
            current_reg     <= current_next;
            started_reg     <= started_next;
            total_reg       <= total_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_THREADS; i++)
            begin
                slice_count_reg[i] <= '0;
            end
        end
        else if (fire && sc_we)
        begin
            slice_count_reg[current_reg] <= sc_wdata;
        end
    end

    // links carry no reset, an entry is only read after it was written
    always_ff @(posedge clk)
    begin
        if (fire && nl_we)
        begin
            next_link_reg[nl_waddr] <= nl_wdata;
        end
        if (fire && pl_we)
        begin
            prev_link_reg[pl_waddr] <= pl_wdata;
        end
    end

endmodule

@@ hdl/rrqs_out_reg.sv @@
// ----------------------------------------------------------------------------
// rrqs_out_reg
// result register: holds one response until the consumer takes it
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rrqs_out_reg (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           load,
    input  rrqs_pkg::rsp_t rsp_next,
    output logic           room,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output rrqs_pkg::rsp_t rsp
);
    import rrqs_pkg::*;

    logic valid_reg;
    logic valid_next;
    rsp_t rsp_reg;

    assign room       = !valid_reg || !rsp_stall;
    assign valid_next = load ? 1'b1 : (room ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = valid_reg;
    assign rsp       = rsp_reg;

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench for round_robin_quantum_scheduler_top
// A table of directed requests covers start-up, the error statuses and the
// queue corner cases. Random requests follow under several quantum settings
// and stall patterns. Every response is compared field by field against a
// scoreboard fed by the table or by a behavioral run-queue scheduler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import rrqs_pkg::*;

    localparam int LIMIT_CYCLES  = 200000;
    localparam int SETTLE_CYCLES = 3;
    localparam int HOLD_CYCLES   = 200;

    typedef struct {
        cmd_t                cmd;
        logic [THREAD_W-1:0] id;
        bit                  typed;
        rsp_t                want;
    } dir_row_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [QUANTUM_W-1:0] cfg_wdata = '0;
    logic                 req_valid = 1'b0;
    logic                 req_stall;
    req_t                 req       = '0;
    logic                 rsp_valid;
    logic                 rsp_stall = 1'b0;
    rsp_t                 rsp;

    // behavioral scheduler state
    logic [THREAD_W-1:0]  link_next [MAX_THREADS];
    logic [THREAD_W-1:0]  link_prev [MAX_THREADS];
    logic [QUANTUM_W-1:0] slice_used [MAX_THREADS];
    logic [MAX_THREADS-1:0] queued  = '0;
    int unsigned          queue_len = 0;
    logic [THREAD_W-1:0]  head_thr  = '0;
    logic [THREAD_W-1:0]  tail_thr  = '0;
    logic [THREAD_W-1:0]  cur_thr   = '0;
    logic                 started   = 1'b0;
    logic [TOTAL_W-1:0]   ticks_seen = '0;
    logic [QUANTUM_W-1:0] quantum   = QUANTUM_RESET;

    rsp_t     pending_rsp [$];
    dir_row_t dir_rows [$];
    int       mismatches   = 0;
    int       rsp_count    = 0;
    int       cycles       = 0;
    int       snd_idle_pct = 0;
    int       rcv_idle_pct = 0;
    bit       hold_arm     = 1'b0;
    int       hold_left    = 0;

    round_robin_quantum_scheduler_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #6 clk = ~clk;

    function automatic rsp_t next_schedule(req_t r);
        rsp_t                 o;
        logic [QUANTUM_W:0]   bumped;
        logic [THREAD_W-1:0]  succ;
        logic [THREAD_W-1:0]  id;
        o        = '0;
        o.status = ST_OK;
        id       = r.thread_id;
        case (r.cmd)
            CMD_TICK:
            begin
                if (!started)
                begin
                    if (queue_len == 0)
                        o.status = ST_EMPTY;
                    else
                    begin
                        cur_thr    = head_thr;
                        started    = 1'b1;
                        o.switched = 1'b1;
                    end
                end
                else
                begin
                    ticks_seen = ticks_seen + TOTAL_W'(1);
                    // compared one bit wider so a full counter never wraps
                    bumped = {1'b0, slice_used[cur_thr]} + (QUANTUM_W+1)'(1);
                    if (bumped > {1'b0, quantum})
                    begin
                        slice_used[cur_thr] = '0;
                        if (queue_len != 0)
                        begin
                            // a dequeued current thread hands over to the head
                            if (!queued[cur_thr] || cur_thr == tail_thr)
                                succ = head_thr;
                            else
                                succ = link_next[cur_thr];
                            if (succ != cur_thr)
                            begin
                                cur_thr    = succ;
                                o.switched = 1'b1;
                            end
                        end
                    end
                    else
                        slice_used[cur_thr] = bumped[QUANTUM_W-1:0];
                end
            end
            CMD_ENQUEUE:
            begin
                if (queued[id])
                    o.status = ST_DUP;
                else
                begin
                    if (queue_len == 0)
                        head_thr = id;
                    else
                    begin
                        link_next[tail_thr] = id;
                        link_prev[id]       = tail_thr;
                    end
                    tail_thr   = id;
                    queued[id] = 1'b1;
                    queue_len++;
                end
            end
            CMD_DEQUEUE:
            begin
                if (!queued[id])
                    o.status = ST_ABSENT;
                else
                begin
                    if (id == head_thr && id == tail_thr)
                    begin
                        head_thr = '0;
                        tail_thr = '0;
                    end
                    else if (id == head_thr)
                        head_thr = link_next[id];
                    else if (id == tail_thr)
                        tail_thr = link_prev[id];
                    else
                    begin
                        link_next[link_prev[id]] = link_next[id];
                        link_prev[link_next[id]] = link_prev[id];
                    end
                    queued[id] = 1'b0;
                    queue_len--;
                end
            end
            CMD_YIELD:
                slice_used[cur_thr] = quantum;
        endcase
        o.running_thread = cur_thr;
        o.running        = started;
        o.total_ticks    = ticks_seen;
        return o;
    endfunction

    // thread whose queued bit matches, searched from a random start
    function automatic logic [THREAD_W-1:0] pick_thread(logic want_queued);
        int unsigned         base;
        logic [THREAD_W-1:0] t;
        base = $urandom_range(0, MAX_THREADS - 1);
        for (int k = 0; k < MAX_THREADS; k++)
        begin
            t = THREAD_W'(base + k);
            if (queued[t] == want_queued)
                return t;
        end
        return THREAD_W'($urandom_range(0, MAX_THREADS - 1));
    endfunction

    function automatic req_t random_request(int tick_pct);
        req_t        r;
        int unsigned roll;
        r.thread_id = THREAD_W'($urandom_range(0, MAX_THREADS - 1));
        roll = $urandom_range(0, 99);
        if (roll < tick_pct)
            r.cmd = CMD_TICK;
        else
        begin
            roll = $urandom_range(0, 99);
            if (roll < 45)
            begin
                r.cmd = CMD_ENQUEUE;
                if ($urandom_range(0, 3) != 0)
                    r.thread_id = pick_thread(1'b0);
            end
            else if (roll < 80)
            begin
                r.cmd = CMD_DEQUEUE;
                if ($urandom_range(0, 3) != 0)
                    r.thread_id = pick_thread(1'b1);
            end
            else
                r.cmd = CMD_YIELD;
        end
        return r;
    endfunction

    function automatic dir_row_t mk_row(cmd_t c, logic [THREAD_W-1:0] id, bit typed,
                                        logic [THREAD_W-1:0] thr, bit sw, bit run,
                                        status_t st, logic [TOTAL_W-1:0] tot);
        dir_row_t d;
        d.cmd                 = c;
        d.id                  = id;
        d.typed               = typed;
        d.want.running_thread = thr;
        d.want.switched       = sw;
        d.want.running        = run;
        d.want.status         = st;
        d.want.total_ticks    = tot;
        return d;
    endfunction

    function automatic dir_row_t predicted_row(cmd_t c, logic [THREAD_W-1:0] id);
        return mk_row(c, id, 1'b0, '0, 1'b0, 1'b0, ST_OK, '0);
    endfunction

    task automatic send_request(req_t r, bit typed, rsp_t want);
        rsp_t predicted;
        while ($urandom_range(0, 99) < snd_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req       <= r;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall);
        predicted = next_schedule(r);
        pending_rsp.push_back(typed ? want : predicted);
        @(negedge clk);
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_rsp.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_quantum(logic [QUANTUM_W-1:0] value);
        drain();
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(negedge clk);
        cfg_we    <= 1'b0;
        quantum = value;
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch in %s on response %0d: got 0x%0h, expected 0x%0h",
                 what, rsp_count, got, want);
        mismatches++;
    endtask

    always @(negedge clk)
    begin
        if (hold_arm)
        begin
            hold_left = HOLD_CYCLES;
            hold_arm  = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            rsp_stall <= 1'b1;
        end
        else
            rsp_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
    end

    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            rsp_count++;
            if (pending_rsp.size() == 0)
                report_mismatch("response with no request pending",
                                32'(rsp.running_thread), '0);
            else
            begin
                want = pending_rsp.pop_front();
                if (rsp.running_thread !== want.running_thread)
                    report_mismatch("running_thread", 32'(rsp.running_thread),
                                    32'(want.running_thread));
                if (rsp.switched !== want.switched)
                    report_mismatch("switched", 32'(rsp.switched), 32'(want.switched));
                if (rsp.running !== want.running)
                    report_mismatch("running", 32'(rsp.running), 32'(want.running));
                if (rsp.status !== want.status)
                    report_mismatch("status", 32'(rsp.status), 32'(want.status));
                if (rsp.total_ticks !== want.total_ticks)
                    report_mismatch("total_ticks", rsp.total_ticks, want.total_ticks);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles = cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("** round_robin_quantum_scheduler_top: FAILED **");
            $finish;
        end
    end

    initial
    begin
        rsp_t none;
        req_t r;
        none = '0;
        for (int t = 0; t < MAX_THREADS; t++)
        begin
            link_next[t]  = '0;
            link_prev[t]  = '0;
            slice_used[t] = '0;
        end

        // yield before start still loads the counter of thread 0
        dir_rows.push_back(mk_row(CMD_YIELD,   4'hF, 1'b1, 4'd0, 1'b0, 1'b0, ST_OK,     '0));
        dir_rows.push_back(mk_row(CMD_TICK,    4'hA, 1'b1, 4'd0, 1'b0, 1'b0, ST_EMPTY,  '0));
        dir_rows.push_back(mk_row(CMD_DEQUEUE, 4'd5, 1'b1, 4'd0, 1'b0, 1'b0, ST_ABSENT, '0));
        dir_rows.push_back(mk_row(CMD_ENQUEUE, 4'd0, 1'b1, 4'd0, 1'b0, 1'b0, ST_OK,     '0));
        dir_rows.push_back(mk_row(CMD_ENQUEUE, 4'hF, 1'b1, 4'd0, 1'b0, 1'b0, ST_OK,     '0));
        dir_rows.push_back(mk_row(CMD_ENQUEUE, 4'd0, 1'b1, 4'd0, 1'b0, 1'b0, ST_DUP,    '0));
        dir_rows.push_back(mk_row(CMD_ENQUEUE, 4'd7, 1'b1, 4'd0, 1'b0, 1'b0, ST_OK,     '0));
        dir_rows.push_back(mk_row(CMD_TICK,    4'd3, 1'b1, 4'd0, 1'b1, 1'b1, ST_OK,     '0));
        dir_rows.push_back(predicted_row(CMD_TICK,    4'd0));
        dir_rows.push_back(predicted_row(CMD_YIELD,   4'd0));
        dir_rows.push_back(predicted_row(CMD_TICK,    4'hF));
        // tail thread leaves the queue, then the current thread wraps to the head
        dir_rows.push_back(predicted_row(CMD_DEQUEUE, 4'd7));
        dir_rows.push_back(predicted_row(CMD_YIELD,   4'd2));
        dir_rows.push_back(predicted_row(CMD_TICK,    4'd1));
        // single thread left: successor is itself
        dir_rows.push_back(predicted_row(CMD_DEQUEUE, 4'hF));
        dir_rows.push_back(predicted_row(CMD_YIELD,   4'd9));
        dir_rows.push_back(predicted_row(CMD_TICK,    4'd6));
        // empty queue at a switch keeps the current thread
        dir_rows.push_back(predicted_row(CMD_DEQUEUE, 4'd0));
        dir_rows.push_back(predicted_row(CMD_YIELD,   4'd4));
        dir_rows.push_back(predicted_row(CMD_TICK,    4'd8));
        dir_rows.push_back(predicted_row(CMD_ENQUEUE, 4'd3));
        dir_rows.push_back(predicted_row(CMD_ENQUEUE, 4'd9));
        dir_rows.push_back(predicted_row(CMD_ENQUEUE, 4'd12));
        dir_rows.push_back(predicted_row(CMD_DEQUEUE, 4'd9));
        dir_rows.push_back(predicted_row(CMD_DEQUEUE, 4'd3));

        snd_idle_pct = 20;
        rcv_idle_pct = 76;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
        begin
            r.cmd       = dir_rows[i].cmd;
            r.thread_id = dir_rows[i].id;
            send_request(r, dir_rows[i].typed, dir_rows[i].want);
        end

        // shortest slice: a slice runs out on every second tick
        set_quantum(8'd1);
        repeat (350) send_request(random_request(50), 1'b0, none);

        // longest slice, mostly ticks so yields and full counters show up
        set_quantum(8'd255);
        snd_idle_pct = 76;
        rcv_idle_pct = 20;
        repeat (300) send_request(random_request(85), 1'b0, none);

        set_quantum(QUANTUM_W'($urandom_range(2, 30)));
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        for (int n = 0; n < 450; n++)
        begin
            // long receiver hold-off while requests keep coming
            if (n == 100)
                hold_arm = 1'b1;
            if (n == 300)
                drain();
            send_request(random_request(45), 1'b0, none);
        end

        drain();
        if (mismatches == 0)
            $display("** round_robin_quantum_scheduler_top: PASSED **");
        else
            $display("** round_robin_quantum_scheduler_top: FAILED **");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/rrqs_pkg.sv
hdl/rrqs_in_reg.sv
hdl/rrqs_core.sv
hdl/rrqs_out_reg.sv
hdl/round_robin_quantum_scheduler_top.sv
tb/testbench.sv
